/* hw/rtl/rmq_pkg.sv */
package rmq_pkg;

  typedef logic [1:0] branch_t;

  localparam branch_t BR_TRACE = 2'd0;
  localparam branch_t BR_X     = 2'd1;
  localparam branch_t BR_Y     = 2'd2;
  localparam branch_t BR_Z     = 2'd3;

  // three quotient lanes: the non-leading components
  localparam int NLANES = 3;

endpackage

/* hw/rtl/rmq_if.sv */
interface rmq_in_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] col0_row0;
  logic signed [W-1:0] col0_row1;
  logic signed [W-1:0] col0_row2;
  logic signed [W-1:0] col1_row0;
  logic signed [W-1:0] col1_row1;
  logic signed [W-1:0] col1_row2;
  logic signed [W-1:0] col2_row0;
  logic signed [W-1:0] col2_row1;
  logic signed [W-1:0] col2_row2;

  modport source (
    output valid, col0_row0, col0_row1, col0_row2, col1_row0, col1_row1, col1_row2,
           col2_row0, col2_row1, col2_row2,
    input  ready
  );
  modport sink (
    input  valid, col0_row0, col0_row1, col0_row2, col1_row0, col1_row1, col1_row2,
           col2_row0, col2_row1, col2_row2,
    output ready
  );
endinterface

interface rmq_out_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] quat_w;
  logic signed [W-1:0] quat_x;
  logic signed [W-1:0] quat_y;
  logic signed [W-1:0] quat_z;
  logic [1:0]          branch_taken;
  logic                radicand_bad;

  modport source (
    output valid, quat_w, quat_x, quat_y, quat_z, branch_taken, radicand_bad,
    input  ready
  );
  modport sink (
    input  valid, quat_w, quat_x, quat_y, quat_z, branch_taken, radicand_bad,
    output ready
  );
endinterface

/* hw/rtl/rmq_prep.sv */
module rmq_prep #(
  parameter int ELEM_WIDTH = 16,
  parameter int FRAC_BITS  = 14,
  parameter int AW         = 19,
  parameter int RW         = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          v_i,
  input  logic signed [ELEM_WIDTH-1:0]  m_i [3][3],
  output logic                          v_r,
  output logic [2*RW-1:0]               n_r,
  output rmq_pkg::branch_t              branch_r,
  output logic                          bad_r,
  output logic [rmq_pkg::NLANES-1:0]    neg_r,
  output logic [rmq_pkg::NLANES-1:0][ELEM_WIDTH:0] mag_r
);
  import rmq_pkg::*;

  localparam logic signed [AW-1:0] ONE = AW'(1) <<< FRAC_BITS;

  logic signed [AW-1:0] e [3][3];
  logic signed [AW-1:0] trace;
  logic signed [AW-1:0] rad;
  logic signed [AW-1:0] d [NLANES];
  logic signed [AW-1:0] dabs;
  branch_t              br;
  logic                 bad;
  logic [2*RW-1:0]      n_nxt;
  logic [NLANES-1:0]    neg_nxt;
  logic [NLANES-1:0][ELEM_WIDTH:0] mag_nxt;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        e[c][r] = AW'(m_i[c][r]);
      end
    end
    trace = e[0][0] + e[1][1] + e[2][2];
    if (trace > 0) begin
      br   = BR_TRACE;
      rad  = trace + ONE;
      d[0] = e[1][2] - e[2][1];
      d[1] = e[2][0] - e[0][2];
      d[2] = e[0][1] - e[1][0];
    end else begin
      // strict compares: lower index leads on a tie
      br = BR_X;
      if (e[1][1] > e[0][0]) br = BR_Y;
      if (br == BR_X) begin
        if (e[2][2] > e[0][0]) br = BR_Z;
      end else begin
        if (e[2][2] > e[1][1]) br = BR_Z;
      end
      case (br)
        BR_Y: begin
          rad  = e[1][1] - e[2][2] - e[0][0] + ONE;
          d[0] = e[1][2] + e[2][1];
          d[1] = e[1][0] + e[0][1];
          d[2] = e[2][0] - e[0][2];
        end
        BR_Z: begin
          rad  = e[2][2] - e[0][0] - e[1][1] + ONE;
          d[0] = e[2][0] + e[0][2];
          d[1] = e[2][1] + e[1][2];
          d[2] = e[0][1] - e[1][0];
        end
        default: begin
          rad  = e[0][0] - e[1][1] - e[2][2] + ONE;
          d[0] = e[0][1] + e[1][0];
          d[1] = e[0][2] + e[2][0];
          d[2] = e[1][2] - e[2][1];
        end
      endcase
    end
    bad   = (rad <= 0);
    n_nxt = {{(2*RW-(AW-1)){1'b0}}, rad[AW-2:0]} << FRAC_BITS;
    dabs  = '0;
    for (int l = 0; l < NLANES; l++) begin
      neg_nxt[l] = d[l][AW-1];
      dabs       = neg_nxt[l] ? -d[l] : d[l];
      mag_nxt[l] = dabs[ELEM_WIDTH:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r      <= n_nxt;
      branch_r <= br;
      bad_r    <= bad;
      neg_r    <= neg_nxt;
      mag_r    <= mag_nxt;
    end
  end

endmodule

/* hw/rtl/rmq_sqrt_cell.sv */
module rmq_sqrt_cell #(
  parameter int RW = 16,
  parameter int SW = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            v_i,
  input  logic [RW:0]     rem_i,
  input  logic [RW-1:0]   q_i,
  input  logic [2*RW-1:0] n_i,
  input  logic [SW-1:0]   side_i,
  output logic            v_r,
  output logic [RW:0]     rem_r,
  output logic [RW-1:0]   q_r,
  output logic [2*RW-1:0] n_r,
  output logic [SW-1:0]   side_r
);

  logic [RW+2:0] rem_s;
  logic [RW+2:0] trial;
  logic [RW+2:0] diff;
  logic          ge;

  // one root bit per cell: bring down two radicand bits, try 4q+1
  always_comb begin
    rem_s = {rem_i, n_i[2*RW-1 -: 2]};
    trial = {1'b0, q_i, 2'b01};
    diff  = rem_s - trial;
    ge    = (rem_s >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= ge ? diff[RW:0] : rem_s[RW:0];
      q_r    <= {q_i[RW-2:0], ge};
      n_r    <= {n_i[2*RW-3:0], 2'b00};
      side_r <= side_i;
    end
  end

endmodule

/* hw/rtl/rmq_div_cell.sv */
module rmq_div_cell #(
  parameter int RW = 16,
  parameter int NW = 32,
  parameter int SW = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  v_i,
  input  logic [RW:0]                           d_i,
  input  logic [rmq_pkg::NLANES-1:0][RW:0]      rem_i,
  input  logic [rmq_pkg::NLANES-1:0][NW-1:0]    numq_i,
  input  logic [SW-1:0]                         side_i,
  output logic                                  v_r,
  output logic [RW:0]                           d_r,
  output logic [rmq_pkg::NLANES-1:0][RW:0]      rem_r,
  output logic [rmq_pkg::NLANES-1:0][NW-1:0]    numq_r,
  output logic [SW-1:0]                         side_r
);
  import rmq_pkg::*;

  logic [RW+1:0]                rem_s [NLANES];
  logic [RW+1:0]                diff  [NLANES];
  logic [NLANES-1:0]            ge;
  logic [NLANES-1:0][RW:0]      rem_nxt;
  logic [NLANES-1:0][NW-1:0]    numq_nxt;

  // one quotient bit per cell and lane: numerator bits shift out, quotient bits in
  always_comb begin
    for (int l = 0; l < NLANES; l++) begin
      rem_s[l]    = {rem_i[l], numq_i[l][NW-1]};
      diff[l]     = rem_s[l] - {1'b0, d_i};
      ge[l]       = (rem_s[l] >= {1'b0, d_i});
      rem_nxt[l]  = ge[l] ? diff[l][RW:0] : rem_s[l][RW:0];
      numq_nxt[l] = {numq_i[l][NW-2:0], ge[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r    <= d_i;
      rem_r  <= rem_nxt;
      numq_r <= numq_nxt;
      side_r <= side_i;
    end
  end

endmodule

/* hw/rtl/rotation_matrix_to_quaternion.sv */
// Pipeline: input register, RW square root cells, divider setup register, NW
// divider cells and output register, where NW = ELEM_WIDTH + FRAC_BITS + 2 and
// RW = (max(ELEM_WIDTH, FRAC_BITS+1) + 3 + FRAC_BITS) / 2.
// Throughput: one request per cycle unless the sink stalls; the whole cell chain
// holds while the output register waits on a stalled sink.
// Reset: synchronous active-low rst_n clears every valid bit; no pass needed.
module rotation_matrix_to_quaternion #(
  parameter int ELEM_WIDTH = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic      clk,
  input  logic      rst_n,
  rmq_in_if.sink    in_ch,
  rmq_out_if.source out_ch
);
  import rmq_pkg::*;

  localparam int AW  = ((ELEM_WIDTH > FRAC_BITS + 1) ? ELEM_WIDTH : FRAC_BITS + 1) + 3;
  localparam int RW  = (AW + FRAC_BITS) / 2;
  localparam int NW  = ELEM_WIDTH + FRAC_BITS + 2;
  localparam int MW  = ELEM_WIDTH + 1;
  localparam int SW1 = 6 + NLANES * MW;
  localparam int SW2 = 6 + RW;

  localparam logic [NW-1:0] MAX_MAG = {{(NW-ELEM_WIDTH+1){1'b0}}, {(ELEM_WIDTH-1){1'b1}}};
  localparam logic [NW-1:0] ONE_MAG = NW'(1) << FRAC_BITS;

  logic en;
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // input stage
  logic signed [ELEM_WIDTH-1:0] m_in [3][3];
  logic                         pr_v;
  logic [2*RW-1:0]              pr_n;
  branch_t                      pr_branch;
  logic                         pr_bad;
  logic [NLANES-1:0]            pr_neg;
  logic [NLANES-1:0][MW-1:0]    pr_mag;

  assign m_in[0][0] = in_ch.col0_row0;
  assign m_in[0][1] = in_ch.col0_row1;
  assign m_in[0][2] = in_ch.col0_row2;
  assign m_in[1][0] = in_ch.col1_row0;
  assign m_in[1][1] = in_ch.col1_row1;
  assign m_in[1][2] = in_ch.col1_row2;
  assign m_in[2][0] = in_ch.col2_row0;
  assign m_in[2][1] = in_ch.col2_row1;
  assign m_in[2][2] = in_ch.col2_row2;

  rmq_prep #(
    .ELEM_WIDTH (ELEM_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .AW         (AW),
    .RW         (RW)
  ) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .v_i      (in_ch.valid),
    .m_i      (m_in),
    .v_r      (pr_v),
    .n_r      (pr_n),
    .branch_r (pr_branch),
    .bad_r    (pr_bad),
    .neg_r    (pr_neg),
    .mag_r    (pr_mag)
  );

  // square root chain
  logic            sq_v    [RW+1];
  logic [RW:0]     sq_rem  [RW+1];
  logic [RW-1:0]   sq_q    [RW+1];
  logic [2*RW-1:0] sq_n    [RW+1];
  logic [SW1-1:0]  sq_side [RW+1];

  assign sq_v[0]    = pr_v;
  assign sq_rem[0]  = '0;
  assign sq_q[0]    = '0;
  assign sq_n[0]    = pr_n;
  assign sq_side[0] = {pr_branch, pr_bad, pr_neg, pr_mag};

  for (genvar g = 0; g < RW; g++) begin : g_sq
    rmq_sqrt_cell #(
      .RW (RW),
      .SW (SW1)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .v_i    (sq_v[g]),
      .rem_i  (sq_rem[g]),
      .q_i    (sq_q[g]),
      .n_i    (sq_n[g]),
      .side_i (sq_side[g]),
      .v_r    (sq_v[g+1]),
      .rem_r  (sq_rem[g+1]),
      .q_r    (sq_q[g+1]),
      .n_r    (sq_n[g+1]),
      .side_r (sq_side[g+1])
    );
  end

  // divider setup: numerator mag * 2^F + root (rounds), divisor 2 * root
  branch_t                   sq_branch;
  logic                      sq_bad;
  logic [NLANES-1:0]         sq_neg;
  logic [NLANES-1:0][MW-1:0] sq_mag;
  logic [RW-1:0]             root;
  logic                      su_v_r;
  logic [RW:0]               su_d_r;
  logic [NLANES-1:0][NW-1:0] su_numq_r;
  logic [SW2-1:0]            su_side_r;

  assign {sq_branch, sq_bad, sq_neg, sq_mag} = sq_side[RW];
  assign root = sq_q[RW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      su_v_r <= 1'b0;
    end else if (en) begin
      su_v_r <= sq_v[RW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      su_d_r    <= {root, 1'b0};
      su_side_r <= {sq_branch, sq_bad, sq_neg, root};
      for (int l = 0; l < NLANES; l++) begin
        su_numq_r[l] <= (NW'(sq_mag[l]) << FRAC_BITS) + NW'(root);
      end
    end
  end

  // divider chain
  logic                      dv_v    [NW+1];
  logic [RW:0]               dv_d    [NW+1];
  logic [NLANES-1:0][RW:0]   dv_rem  [NW+1];
  logic [NLANES-1:0][NW-1:0] dv_numq [NW+1];
  logic [SW2-1:0]            dv_side [NW+1];

  assign dv_v[0]    = su_v_r;
  assign dv_d[0]    = su_d_r;
  assign dv_rem[0]  = '0;
  assign dv_numq[0] = su_numq_r;
  assign dv_side[0] = su_side_r;

  for (genvar g = 0; g < NW; g++) begin : g_dv
    rmq_div_cell #(
      .RW (RW),
      .NW (NW),
      .SW (SW2)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .v_i    (dv_v[g]),
      .d_i    (dv_d[g]),
      .rem_i  (dv_rem[g]),
      .numq_i (dv_numq[g]),
      .side_i (dv_side[g]),
      .v_r    (dv_v[g+1]),
      .d_r    (dv_d[g+1]),
      .rem_r  (dv_rem[g+1]),
      .numq_r (dv_numq[g+1]),
      .side_r (dv_side[g+1])
    );
  end

  // saturate a sign-magnitude value to the element range
  function automatic logic [ELEM_WIDTH-1:0] sat_mag(input logic [NW-1:0] mag,
                                                    input logic neg);
    logic [NW-1:0] negv;
    negv = ~mag + 1'b1;
    if (neg) begin
      if (mag > MAX_MAG + 1'b1) begin
        return {1'b1, {(ELEM_WIDTH-1){1'b0}}};
      end
      return negv[ELEM_WIDTH-1:0];
    end
    if (mag > MAX_MAG) begin
      return {1'b0, {(ELEM_WIDTH-1){1'b1}}};
    end
    return mag[ELEM_WIDTH-1:0];
  endfunction

  branch_t                       dv_branch;
  logic                          dv_bad;
  logic [NLANES-1:0]             dv_neg;
  logic [RW-1:0]                 dv_root;
  logic [ELEM_WIDTH-1:0]         lead;
  logic [NLANES-1:0][ELEM_WIDTH-1:0] lane;
  logic [ELEM_WIDTH-1:0]         w_nxt, x_nxt, y_nxt, z_nxt;
  logic                          out_v_r;
  logic [ELEM_WIDTH-1:0]         w_r, x_r, y_r, z_r;
  branch_t                       branch_r;
  logic                          bad_r;

  assign {dv_branch, dv_bad, dv_neg, dv_root} = dv_side[NW];

  always_comb begin
    lead = sat_mag(NW'(dv_root >> 1), 1'b0);
    for (int l = 0; l < NLANES; l++) begin
      lane[l] = sat_mag(dv_numq[NW][l], dv_neg[l]);
    end
    case (dv_branch)
      BR_TRACE: begin
        w_nxt = lead;    x_nxt = lane[0]; y_nxt = lane[1]; z_nxt = lane[2];
      end
      BR_X: begin
        x_nxt = lead;    y_nxt = lane[0]; z_nxt = lane[1]; w_nxt = lane[2];
      end
      BR_Y: begin
        y_nxt = lead;    z_nxt = lane[0]; x_nxt = lane[1]; w_nxt = lane[2];
      end
      default: begin
        z_nxt = lead;    x_nxt = lane[0]; y_nxt = lane[1]; w_nxt = lane[2];
      end
    endcase
    // bad radicand: identity quaternion
    if (dv_bad) begin
      w_nxt = sat_mag(ONE_MAG, 1'b0);
      x_nxt = '0;
      y_nxt = '0;
      z_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= dv_v[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_r      <= w_nxt;
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      z_r      <= z_nxt;
      branch_r <= dv_branch;
      bad_r    <= dv_bad;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.quat_w       = w_r;
  assign out_ch.quat_x       = x_r;
  assign out_ch.quat_y       = y_r;
  assign out_ch.quat_z       = z_r;
  assign out_ch.branch_taken = branch_r;
  assign out_ch.radicand_bad = bad_r;

`ifndef SYNTHESIS
  a_trace_never_bad: assert property (@(posedge clk) disable iff (!rst_n)
    (pr_v && pr_branch == BR_TRACE) |-> !pr_bad)
    else $error("trace path flagged a bad radicand");

  a_root_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (sq_v[RW] && !sq_bad) |-> (root != '0))
    else $error("zero root on a good radicand");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(dv_v[NW]) && $stable(dv_side[NW])))
    else $error("divider chain moved while output stalled");

  a_bad_identity: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && bad_r) |-> (x_r == '0 && y_r == '0 && z_r == '0 && branch_r != BR_TRACE))
    else $error("bad radicand result is not identity");
`endif

endmodule

/* tb/rmq_tb_if.sv */
`timescale 1ns / 1ps

// The block's ports are interfaces from the RTL (rmq_in_if, rmq_out_if), so this file
// only holds the channel structs that the stimulus and the checker use.
package rmq_tb_pkg;

  typedef struct packed {
    logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  } rot_mat_t;

  typedef struct packed {
    logic signed [15:0] w, x, y, z;
    logic [1:0]         br;
    logic               bad;
  } quat_res_t;

endpackage

/* tb/rmq_checker.sv */
`timescale 1ns / 1ps

module rmq_checker (
  input  logic  clk,
  input  logic  rst_n,
  rmq_in_if     in_ch,
  rmq_out_if    out_ch,
  output int    fail_count,
  output int    pending
);
  import rmq_pkg::*;
  import rmq_tb_pkg::*;

  localparam int FB = 14;
  localparam longint ONE = 64'sd1 <<< FB;

  quat_res_t quat_queue[$];

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint int_sqrt(longint n);
    longint res, bitv;
    res = 0;
    bitv = 64'sd1 <<< 62;
    while (bitv > n) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >>> 1) + bitv;
      end else begin
        res = res >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return res;
  endfunction

  // round to nearest, ties away from zero
  function automatic longint div_by_root(longint d, longint root);
    longint mag, q;
    mag = (d < 0) ? -d : d;
    q = ((mag <<< FB) + root) / (2 * root);
    return (d < 0) ? -q : q;
  endfunction

  function automatic quat_res_t predict_quat(rot_mat_t mi);
    longint m[3][3];
    longint q[4];
    longint tr, rad, root;
    int i, j, k;
    quat_res_t res;
    m[0][0] = mi.m00; m[0][1] = mi.m01; m[0][2] = mi.m02;
    m[1][0] = mi.m10; m[1][1] = mi.m11; m[1][2] = mi.m12;
    m[2][0] = mi.m20; m[2][1] = mi.m21; m[2][2] = mi.m22;
    res.bad = 1'b0;
    tr = m[0][0] + m[1][1] + m[2][2];
    if (tr > 0) begin
      root = int_sqrt((tr + ONE) <<< FB);
      res.br = BR_TRACE;
      q[0] = root >>> 1;
      q[1] = div_by_root(m[1][2] - m[2][1], root);
      q[2] = div_by_root(m[2][0] - m[0][2], root);
      q[3] = div_by_root(m[0][1] - m[1][0], root);
    end else begin
      i = 0;
      if (m[1][1] > m[0][0]) i = 1;
      if (m[2][2] > m[i][i]) i = 2;
      j = (i + 1) % 3;
      k = (j + 1) % 3;
      res.br = branch_t'(i + 1);
      rad = m[i][i] - m[j][j] - m[k][k] + ONE;
      if (rad <= 0) begin
        res.bad = 1'b1;
        q[0] = ONE; q[1] = 0; q[2] = 0; q[3] = 0;
      end else begin
        root = int_sqrt(rad <<< FB);
        q[1+i] = root >>> 1;
        q[1+j] = div_by_root(m[i][j] + m[j][i], root);
        q[1+k] = div_by_root(m[i][k] + m[k][i], root);
        q[0] = div_by_root(m[j][k] - m[k][j], root);
      end
    end
    res.w = 16'(clamp16(q[0]));
    res.x = 16'(clamp16(q[1]));
    res.y = 16'(clamp16(q[2]));
    res.z = 16'(clamp16(q[3]));
    return res;
  endfunction

  assign pending = quat_queue.size();

  always @(posedge clk) begin
    rot_mat_t mi;
    quat_res_t got, exp_q;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        mi = {in_ch.col0_row0, in_ch.col0_row1, in_ch.col0_row2,
              in_ch.col1_row0, in_ch.col1_row1, in_ch.col1_row2,
              in_ch.col2_row0, in_ch.col2_row1, in_ch.col2_row2};
        quat_queue.push_back(predict_quat(mi));
      end
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.quat_w, out_ch.quat_x, out_ch.quat_y, out_ch.quat_z,
               out_ch.branch_taken, out_ch.radicand_bad};
        if (quat_queue.size() == 0) begin
          $display("%t: unexpected result %p", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          exp_q = quat_queue.pop_front();
          if (got !== exp_q) begin
            $display("%t: mismatch expected %p actual %p", $time, exp_q, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

/* tb/tb_rotation_matrix_to_quaternion.sv */
`timescale 1ns / 1ps

module tb_rotation_matrix_to_quaternion;
  import rmq_tb_pkg::*;

  localparam int LATENCY = 51;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  bit   hold_sink = 1'b0;
  longint cycles = 0;

  rmq_in_if  #(16) in_ch ();
  rmq_out_if #(16) out_ch ();

  rotation_matrix_to_quaternion dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  rmq_checker chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    {in_ch.col0_row0, in_ch.col0_row1, in_ch.col0_row2, in_ch.col1_row0,
     in_ch.col1_row1, in_ch.col1_row2, in_ch.col2_row0, in_ch.col2_row1,
     in_ch.col2_row2} = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("rotation_matrix_to_quaternion verification failed");
      $finish;
    end
  end

  // receiver: random stall, or a long hold-off when asked
  always @(posedge clk) begin
    if (!rst_n || hold_sink) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic signed [15:0] rand_elem();
    case ($urandom_range(5))
      0: return 16'(16384);
      1: return -16'sd16384;
      2: return 16'($urandom);
      3: return 16'($urandom_range(32767));
      default: return 16'($urandom_range(32768) - 16384);
    endcase
  endfunction

  // rotation about a random axis order, half of them with small jitter: hits every branch
  function automatic rot_mat_t rand_rotation();
    rot_mat_t mi;
    int c, s, pick;
    c = int'($urandom_range(32768)) - 16384;
    s = (int'($urandom_range(1)) ? 1 : -1) * int'($sqrt(268435456.0 - real'(c) * c));
    pick = $urandom_range(5);
    mi = '0;
    case (pick % 3)
      0: begin
        mi.m00 = 16'sd16384; mi.m11 = 16'(c); mi.m22 = 16'(c);
        mi.m12 = 16'(s); mi.m21 = 16'(-s);
      end
      1: begin
        mi.m11 = 16'sd16384; mi.m00 = 16'(c); mi.m22 = 16'(c);
        mi.m20 = 16'(s); mi.m02 = 16'(-s);
      end
      default: begin
        mi.m22 = 16'sd16384; mi.m00 = 16'(c); mi.m11 = 16'(c);
        mi.m01 = 16'(s); mi.m10 = 16'(-s);
      end
    endcase
    if (pick >= 3) begin
      mi.m00 = mi.m00 + 16'($urandom_range(6) - 3);
      mi.m21 = mi.m21 + 16'($urandom_range(6) - 3);
    end
    return mi;
  endfunction

  function automatic rot_mat_t rand_noise();
    rot_mat_t mi;
    mi = {rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
          rand_elem(), rand_elem(), rand_elem(), rand_elem()};
    return mi;
  endfunction

  task automatic send_matrix(rot_mat_t mi);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    {in_ch.col0_row0, in_ch.col0_row1, in_ch.col0_row2, in_ch.col1_row0,
     in_ch.col1_row1, in_ch.col1_row2, in_ch.col2_row0, in_ch.col2_row1,
     in_ch.col2_row2} <= mi;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    rot_mat_t mi;
    rot_mat_t directed[$];
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity, half-turns about each axis, ties, extremes
    mi = '0; mi.m00 = 16'sd16384; mi.m11 = 16'sd16384; mi.m22 = 16'sd16384;
    directed.push_back(mi);
    mi = '0; mi.m00 = 16'sd16384; mi.m11 = -16'sd16384; mi.m22 = -16'sd16384;
    directed.push_back(mi);
    mi = '0; mi.m00 = -16'sd16384; mi.m11 = 16'sd16384; mi.m22 = -16'sd16384;
    directed.push_back(mi);
    mi = '0; mi.m00 = -16'sd16384; mi.m11 = -16'sd16384; mi.m22 = 16'sd16384;
    directed.push_back(mi);
    mi = '0; directed.push_back(mi);
    mi = '1; directed.push_back(mi);
    mi = {9{16'sh7fff}}; directed.push_back(mi);
    mi = {9{16'sh8000}}; directed.push_back(mi);
    mi = {16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
          16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000}; directed.push_back(mi);
    mi = {16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
          16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff}; directed.push_back(mi);
    // huge off-diagonals, x branch
    mi = {-16'sd16383, 16'sh7fff, 16'sh8000, 16'sh8000, -16'sd16384,
          16'sh7fff, 16'sh7fff, 16'sh8000, -16'sd16384}; directed.push_back(mi);
    // negative and mixed-sign diagonals
    mi = '0; mi.m00 = -16'sd16384; mi.m11 = -16'sd16384; mi.m22 = -16'sd16384;
    directed.push_back(mi);
    mi = '0; mi.m00 = -16'sd20000; mi.m11 = 16'sh7fff; mi.m22 = 16'sh7fff;
    mi.m00 = 16'sh8000;
    directed.push_back(mi);
    foreach (directed[n]) send_matrix(directed[n]);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      if (ph == 2) begin
        // long hold-off: fill the pipe and stall the input
        fork
          begin
            hold_sink = 1'b1;
            repeat (150) @(posedge clk);
            hold_sink = 1'b0;
          end
          for (int n = 0; n < 100; n++) send_matrix(rand_rotation());
        join
      end
      for (int n = 0; n < 440; n++)
        send_matrix(($urandom_range(99) < 70) ? rand_rotation() : rand_noise());
      // pause until every result is back
      drain();
    end

    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0) $display("rotation_matrix_to_quaternion verification clean");
    else $display("rotation_matrix_to_quaternion verification failed");
    $finish;
  end

endmodule
